@@ rtl/core/rotated_pi_visual_servo_step_unit_defines.svh @@
// Assertion macros shared by the servo step RTL.
`ifndef ROTATED_PI_VISUAL_SERVO_STEP_UNIT_DEFINES_SVH
`define ROTATED_PI_VISUAL_SERVO_STEP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPVS_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPVS_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rpvs_pkg.sv @@
package rpvs_pkg;

  localparam int DEF_GOAL_COUNT    = 4;
  localparam int DEF_CORDIC_STEPS  = 16;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int LABEL_REGS  = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int LABEL_W     = 8;
  localparam int LIMIT_W     = 13;
  localparam int DEADBAND_W  = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LABEL0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd5;

  localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 13'd2000;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 8'd20;

  // binary angle: 2^32 per turn
  localparam int ANG_W      = 33;
  localparam int STEP_IDX_W = 5;
  localparam int ATAN_LEN   = 24;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 33'sh0_4000_0000;
  localparam logic signed [ANG_W-1:0] ANG_HALF    = 33'sh0_8000_0000;

  localparam int GAIN_Q16   = 39797;
  localparam int GAIN_SHIFT = 16;
  localparam int GAIN_HALF  = 32768;

  localparam int STEP_W   = 14;
  localparam int STEP_MAX = 8191;
  localparam int STEP_MIN = -8192;
  localparam int POS_W    = 16;

  localparam int ARENA_X_LO = -700;
  localparam int ARENA_X_HI = 2000;
  localparam int ARENA_Y_LO = -1300;
  localparam int ARENA_Y_HI = 1500;

  localparam int INT_DIV   = 200;
  localparam int INT_ROUND = 100;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  function automatic logic signed [ANG_W-1:0] atan_val(input logic [STEP_IDX_W-1:0] idx);
    unique case (idx)
      5'd0:    atan_val = 33'sd536870912;
      5'd1:    atan_val = 33'sd316933406;
      5'd2:    atan_val = 33'sd167458907;
      5'd3:    atan_val = 33'sd85004756;
      5'd4:    atan_val = 33'sd42667331;
      5'd5:    atan_val = 33'sd21354465;
      5'd6:    atan_val = 33'sd10679838;
      5'd7:    atan_val = 33'sd5340245;
      5'd8:    atan_val = 33'sd2670163;
      5'd9:    atan_val = 33'sd1335087;
      5'd10:   atan_val = 33'sd667544;
      5'd11:   atan_val = 33'sd333772;
      5'd12:   atan_val = 33'sd166886;
      5'd13:   atan_val = 33'sd83443;
      5'd14:   atan_val = 33'sd41722;
      5'd15:   atan_val = 33'sd20861;
      5'd16:   atan_val = 33'sd10430;
      5'd17:   atan_val = 33'sd5215;
      5'd18:   atan_val = 33'sd2608;
      5'd19:   atan_val = 33'sd1304;
      5'd20:   atan_val = 33'sd652;
      5'd21:   atan_val = 33'sd326;
      5'd22:   atan_val = 33'sd163;
      5'd23:   atan_val = 33'sd81;
      default: atan_val = '0;
    endcase
  endfunction

endpackage

@@ rtl/core/rotated_pi_visual_servo_step_unit.sv @@
// Matched request: accept, then the states ROT (CORDIC), GX, GY, GS, INTEG, QX, QY, QW, CORR,
// CTL, MM and FIN, where the result is registered. Unmatched request: IDLE straight to FIN.
// One request in flight; a new one is taken the cycle after the result is registered. The CORDIC
// loop and the shared multiplier (gain and reciprocal steps, one per cycle) dominate that path.
// rst_n (synchronous, active low) clears integrals, goal index, held steps and restores
// the register defaults: labels 0..3, integral limit 2000, deadband 20.
`include "rotated_pi_visual_servo_step_unit_defines.svh"

module rotated_pi_visual_servo_step_unit #(
  parameter int GOAL_COUNT    = rpvs_pkg::DEF_GOAL_COUNT,
  parameter int CORDIC_STEPS  = rpvs_pkg::DEF_CORDIC_STEPS,
  parameter int FRACTION_BITS = rpvs_pkg::DEF_FRACTION_BITS,
  localparam int GW = $clog2(GOAL_COUNT + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_object_class,
  input  logic signed [11:0]                   in_offset_x,
  input  logic signed [11:0]                   in_offset_y,
  input  logic signed [15:0]                   in_heading,
  input  logic signed [15:0]                   in_position_x_mm,
  input  logic signed [15:0]                   in_position_y_mm,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_matched,
  output logic signed [13:0]                   out_step_x_mm,
  output logic signed [13:0]                   out_step_y_mm,
  output logic                                 out_goal_reached,
  output logic [GW-1:0]                        out_goal_number,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rpvs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpvs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DW    = 15 + FRACTION_BITS;   // rotated vector and sums
  localparam int IW    = 14 + FRACTION_BITS;   // integral state
  localparam int MW    = DW + 1;               // multiplier operand
  localparam int RS    = DW + 1;               // reciprocal shift
  localparam int RECIP = (1 << RS) / rpvs_pkg::INT_DIV;
  localparam int QK    = 1 << (FRACTION_BITS + 6);
  localparam int QOFF  = rpvs_pkg::INT_DIV * QK + rpvs_pkg::INT_ROUND;
  localparam int GXW   = (GW > 2) ? GW : 2;
  localparam int SW    = rpvs_pkg::STEP_W;
  localparam int AW    = rpvs_pkg::POS_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROT   = 4'd1;
  localparam logic [3:0] S_GX    = 4'd2;
  localparam logic [3:0] S_GY    = 4'd3;
  localparam logic [3:0] S_GS    = 4'd4;
  localparam logic [3:0] S_INTEG = 4'd5;
  localparam logic [3:0] S_QX    = 4'd6;
  localparam logic [3:0] S_QY    = 4'd7;
  localparam logic [3:0] S_QW    = 4'd8;
  localparam logic [3:0] S_CORR  = 4'd9;
  localparam logic [3:0] S_CTL   = 4'd10;
  localparam logic [3:0] S_MM    = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r, state_nxt;

  logic [rpvs_pkg::LABEL_W-1:0]    lbl_r [rpvs_pkg::LABEL_REGS];
  logic [rpvs_pkg::LIMIT_W-1:0]    lim_r;
  logic [rpvs_pkg::DEADBAND_W-1:0] db_r;

  logic signed [15:0]   pos_x_r, pos_y_r;
  logic                 match_r;
  logic signed [DW-1:0] rx_r, ry_r;
  logic signed [IW-1:0] ix_r, iy_r;
  logic [DW-1:0]        q0x_r, q0y_r;
  logic signed [DW-1:0] qx_r, qy_r;
  logic signed [DW:0]   ux_r, uy_r;
  logic signed [SW-1:0] sx_r, sy_r;
  logic                 reached_r;

  logic signed [SW-1:0] held_x_r, held_y_r, held_x_nxt, held_y_nxt;
  logic [GW-1:0]        goal_r, goal_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_matched_r, out_reached_r;
  logic signed [SW-1:0] out_sx_r, out_sy_r;
  logic [GW-1:0]        out_goal_r;

  logic                   in_acc, match_w, fin_load, x_ok, y_ok;
  logic [GXW-1:0]         goal_ext;
  logic signed [DW-1:0]   cor_x0, cor_y0, cor_x, cor_y;
  rpvs_pkg::cordic_stat_t cor_stat;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p, gain_rnd;
  logic [DW-1:0]          vx, vy;
  logic signed [AW-1:0]   nx, ny;

  function automatic logic signed [IW-1:0] integ_upd(input logic signed [IW-1:0] i,
                                                     input logic signed [DW-1:0] r,
                                                     input logic [rpvs_pkg::LIMIT_W-1:0] lim);
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] l;
    s = DW'(i) + r;
    l = signed'(DW'({lim, FRACTION_BITS'(0)}));
    if (s > l) begin
      s = l;
    end else if (s < -l) begin
      s = -l;
    end
    return IW'(s);
  endfunction

  // integral + rounding + bias that keeps the dividend positive
  function automatic logic [DW-1:0] rec_arg(input logic signed [IW-1:0] i);
    logic signed [DW:0] t;
    t = (DW+1)'(i) + (DW+1)'(QOFF);
    return t[DW-1:0];
  endfunction

  // reciprocal estimate is low by at most one: fix with one compare, drop the bias
  function automatic logic signed [DW-1:0] q_fix(input logic [DW-1:0] q0,
                                                 input logic [DW-1:0] v);
    logic [DW-1:0] rem;
    rem = v - q0 * DW'(rpvs_pkg::INT_DIV);
    return signed'(q0 + DW'(rem >= DW'(rpvs_pkg::INT_DIV)) - DW'(QK));
  endfunction

  function automatic logic signed [DW:0] ctl(input logic signed [DW-1:0] r,
                                             input logic signed [DW-1:0] q,
                                             input logic [rpvs_pkg::DEADBAND_W-1:0] db);
    logic signed [DW:0] u;
    logic signed [DW:0] d;
    u = (DW+1)'(r) + (DW+1)'(q);
    d = signed'((DW+1)'({db, FRACTION_BITS'(0)}));
    if (u > -d && u < d) begin
      u = '0;
    end
    return u;
  endfunction

  function automatic logic signed [SW-1:0] to_mm(input logic signed [DW:0] u);
    logic signed [DW+1:0] t;
    t = ((DW+2)'(u) <<< 1) + (DW+2)'(1 << (FRACTION_BITS - 1));
    t = t >>> FRACTION_BITS;
    if (t > (DW+2)'(rpvs_pkg::STEP_MAX)) begin
      t = (DW+2)'(rpvs_pkg::STEP_MAX);
    end else if (t < (DW+2)'(rpvs_pkg::STEP_MIN)) begin
      t = (DW+2)'(rpvs_pkg::STEP_MIN);
    end
    return SW'(t);
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign goal_ext = GXW'(goal_r);
  assign match_w  = (goal_r < GW'(GOAL_COUNT)) &&
                    (GXW'(goal_r) < GXW'(rpvs_pkg::LABEL_REGS)) &&
                    (in_object_class == lbl_r[goal_ext[1:0]]);

  assign cor_x0 = DW'(in_offset_x) <<< FRACTION_BITS;
  assign cor_y0 = DW'(in_offset_y) <<< FRACTION_BITS;

  rpvs_cordic #(
    .DW    (DW),
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && match_w),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .ang   (in_heading),
    .x_out (cor_x),
    .y_out (cor_y),
    .stat  (cor_stat)
  );

  assign vx = rec_arg(ix_r);
  assign vy = rec_arg(iy_r);

  always_comb begin
    unique case (state_r)
      S_GX: begin
        mul_a = MW'(cor_x);
        mul_b = MW'(rpvs_pkg::GAIN_Q16);
      end
      S_GY: begin
        mul_a = MW'(cor_y);
        mul_b = MW'(rpvs_pkg::GAIN_Q16);
      end
      S_QX: begin
        mul_a = signed'({1'b0, vx});
        mul_b = MW'(RECIP);
      end
      S_QY: begin
        mul_a = signed'({1'b0, vy});
        mul_b = MW'(RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rpvs_mul #(
    .W (MW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign gain_rnd = mul_p + (2*MW)'(rpvs_pkg::GAIN_HALF);

  // arena check on the new position
  assign nx   = AW'(pos_x_r) + AW'(sx_r);
  assign ny   = AW'(pos_y_r) + AW'(sy_r);
  assign x_ok = (nx > AW'(rpvs_pkg::ARENA_X_LO)) && (nx < AW'(rpvs_pkg::ARENA_X_HI));
  assign y_ok = (ny > AW'(rpvs_pkg::ARENA_Y_LO)) && (ny < AW'(rpvs_pkg::ARENA_Y_HI));

  assign fin_load   = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign held_x_nxt = (match_r && x_ok) ? sx_r : held_x_r;
  assign held_y_nxt = (match_r && y_ok) ? sy_r : held_y_r;
  assign goal_nxt   = (match_r && reached_r) ? GW'(goal_r + 1'b1) : goal_r;

  always_comb begin
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) begin
                 state_nxt = match_w ? S_ROT : S_FIN;
               end
      S_ROT:   if (cor_stat.done) begin
                 state_nxt = S_GX;
               end
      S_GX:    state_nxt = S_GY;
      S_GY:    state_nxt = S_GS;
      S_GS:    state_nxt = S_INTEG;
      S_INTEG: state_nxt = S_QX;
      S_QX:    state_nxt = S_QY;
      S_QY:    state_nxt = S_QW;
      S_QW:    state_nxt = S_CORR;
      S_CORR:  state_nxt = S_CTL;
      S_CTL:   state_nxt = S_MM;
      S_MM:    state_nxt = S_FIN;
      S_FIN:   if (fin_load) begin
                 state_nxt = S_IDLE;
               end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers, advanced by the sequencer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_x_r <= in_position_x_mm;
      pos_y_r <= in_position_y_mm;
      match_r <= match_w;
    end
    if (state_r == S_GY) begin
      rx_r <= gain_rnd[rpvs_pkg::GAIN_SHIFT +: DW];
    end
    if (state_r == S_GS) begin
      ry_r <= gain_rnd[rpvs_pkg::GAIN_SHIFT +: DW];
    end
    if (state_r == S_QY) begin
      q0x_r <= mul_p[RS +: DW];
    end
    if (state_r == S_QW) begin
      q0y_r <= mul_p[RS +: DW];
    end
    if (state_r == S_CORR) begin
      qx_r <= q_fix(q0x_r, vx);
      qy_r <= q_fix(q0y_r, vy);
    end
    if (state_r == S_CTL) begin
      ux_r <= ctl(rx_r, qx_r, db_r);
      uy_r <= ctl(ry_r, qy_r, db_r);
    end
    if (state_r == S_MM) begin
      sx_r      <= to_mm(ux_r);
      sy_r      <= to_mm(uy_r);
      reached_r <= (ux_r == '0) && (uy_r == '0);
    end
    if (fin_load) begin
      out_matched_r <= match_r;
      out_reached_r <= match_r && reached_r;
      out_sx_r      <= held_x_nxt;
      out_sy_r      <= held_y_nxt;
      out_goal_r    <= goal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ix_r        <= '0;
      iy_r        <= '0;
      goal_r      <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      lim_r       <= rpvs_pkg::LIMIT_RST;
      db_r        <= rpvs_pkg::DEADBAND_RST;
      for (int k = 0; k < rpvs_pkg::LABEL_REGS; k++) begin
        lbl_r[k] <= rpvs_pkg::LABEL_W'(k);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_INTEG) begin
        ix_r <= integ_upd(ix_r, rx_r, lim_r);
        iy_r <= integ_upd(iy_r, ry_r, lim_r);
      end
      if (fin_load) begin
        goal_r   <= goal_nxt;
        held_x_r <= held_x_nxt;
        held_y_r <= held_y_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rpvs_pkg::REG_LABEL0:   lbl_r[0] <= cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LABEL1:   lbl_r[1] <= cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LABEL2:   lbl_r[2] <= cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LABEL3:   lbl_r[3] <= cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LIMIT:    lim_r    <= cfg_data[rpvs_pkg::LIMIT_W-1:0];
          rpvs_pkg::REG_DEADBAND: db_r     <= cfg_data[rpvs_pkg::DEADBAND_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = out_matched_r;
  assign out_step_x_mm    = out_sx_r;
  assign out_step_y_mm    = out_sy_r;
  assign out_goal_reached = out_reached_r;
  assign out_goal_number  = out_goal_r;

  `RPVS_CHECK_NOW(a_goal_range, 1'b1, goal_r <= GW'(GOAL_COUNT), "goal index past goal count")
  `RPVS_CHECK_NOW(a_cordic_in_rot, cor_stat.busy, state_r == S_ROT, "rotator busy outside ROT")
  `RPVS_CHECK_NEXT(a_fin_hold, (state_r == S_FIN) && out_valid_r && out_stall, state_r == S_FIN, "result dropped under stall")
  `RPVS_CHECK_NOW(a_goal_step, goal_r != $past(goal_r), $past(fin_load && match_r && reached_r), "goal moved without reach")
  `RPVS_CHECK_NOW(a_nomatch_reach, out_valid && !out_matched, !out_goal_reached, "reach flagged on unmatched request")

endmodule

@@ rtl/core/rpvs_mul.sv @@
module rpvs_mul #(
  parameter int W = 24
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  logic signed [2*W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

@@ rtl/core/rpvs_cordic.sv @@
module rpvs_cordic #(
  parameter int DW    = 23,
  parameter int STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [DW-1:0]   x0,
  input  logic signed [DW-1:0]   y0,
  input  logic signed [15:0]     ang,
  output logic signed [DW-1:0]   x_out,
  output logic signed [DW-1:0]   y_out,
  output rpvs_pkg::cordic_stat_t stat
);

  localparam int ZW = rpvs_pkg::ANG_W;
  localparam int CW = rpvs_pkg::STEP_IDX_W;

  logic signed [DW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt, z0, atan;
  logic signed [DW-1:0] dx, dy;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic                 last;

  assign z0   = signed'({{(ZW-32){ang[15]}}, ang, 16'b0});
  assign atan = rpvs_pkg::atan_val(cnt_r);
  assign dx   = y_r >>> cnt_r;
  assign dy   = x_r >>> cnt_r;
  assign last = (cnt_r == CW'(STEPS - 1));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      // fold headings beyond a quarter turn: negate and move by a half turn
      if (z0 > rpvs_pkg::ANG_QUARTER) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = z0 - rpvs_pkg::ANG_HALF;
      end else if (z0 < -rpvs_pkg::ANG_QUARTER) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = z0 + rpvs_pkg::ANG_HALF;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = z0;
      end
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign x_out     = x_r;
  assign y_out     = y_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ tb/servo_step_checker.sv @@
module servo_step_checker #(
  parameter int GOAL_COUNT    = rpvs_pkg::DEF_GOAL_COUNT,
  parameter int CORDIC_STEPS  = rpvs_pkg::DEF_CORDIC_STEPS,
  parameter int FRACTION_BITS = rpvs_pkg::DEF_FRACTION_BITS,
  localparam int GW = $clog2(GOAL_COUNT + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_object_class,
  input  logic signed [11:0]              in_offset_x,
  input  logic signed [11:0]              in_offset_y,
  input  logic signed [15:0]              in_heading,
  input  logic signed [15:0]              in_position_x_mm,
  input  logic signed [15:0]              in_position_y_mm,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_matched,
  input  logic signed [13:0]              out_step_x_mm,
  input  logic signed [13:0]              out_step_y_mm,
  input  logic                            out_goal_reached,
  input  logic [GW-1:0]                   out_goal_number,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rpvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpvs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  typedef struct {
    logic               matched;
    logic signed [13:0] step_x;
    logic signed [13:0] step_y;
    logic               reached;
    logic [GW-1:0]      goal;
  } servo_result_t;

  // arctangent of 2^-i, 2^32 per turn
  localparam longint ATAN_TURN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };
  localparam longint QUARTER_TURN = 64'sd1 << 30;
  localparam longint HALF_TURN    = 64'sd1 << 31;

  logic [rpvs_pkg::LABEL_W-1:0]    goal_label [rpvs_pkg::LABEL_REGS];
  logic [rpvs_pkg::LIMIT_W-1:0]    limit_px;
  logic [rpvs_pkg::DEADBAND_W-1:0] deadband_px;
  longint                          axis_integral [2];
  longint                          held_step [2];
  int                              goal_idx;
  servo_result_t                   steps_due [$];
  servo_result_t                   want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic flag_step_mismatch(input string what, input longint got, input longint exp_v);
    $display("%0t: servo step mismatch on %s: got %0d, want %0d", $realtime, what, got, exp_v);
    fail_count++;
  endtask

  function automatic void rotate_by_heading(input longint ox, input longint oy,
                                            input longint hdg, output longint rx,
                                            output longint ry);
    longint x, y, z, dx, dy;
    x = ox;
    y = oy;
    z = hdg * 65536;
    // fold into the right half plane
    if (z > QUARTER_TURN) begin
      x = -x;
      y = -y;
      z = z - HALF_TURN;
    end else if (z < -QUARTER_TURN) begin
      x = -x;
      y = -y;
      z = z + HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    rx = (x * rpvs_pkg::GAIN_Q16 + rpvs_pkg::GAIN_HALF) >>> rpvs_pkg::GAIN_SHIFT;
    ry = (y * rpvs_pkg::GAIN_Q16 + rpvs_pkg::GAIN_HALF) >>> rpvs_pkg::GAIN_SHIFT;
  endfunction

  function automatic longint axis_effort(input int axis, input longint r);
    longint lim, db, acc, num, quo, u;
    lim = longint'(limit_px) << FRACTION_BITS;
    db  = longint'(deadband_px) << FRACTION_BITS;
    acc = axis_integral[axis] + r;
    if (acc > lim)
      acc = lim;
    else if (acc < -lim)
      acc = -lim;
    axis_integral[axis] = acc;
    // floor division of the rounded integral
    num = acc + rpvs_pkg::INT_ROUND;
    quo = num / rpvs_pkg::INT_DIV;
    if ((num % rpvs_pkg::INT_DIV) != 0 && num < 0)
      quo = quo - 1;
    u = r + quo;
    if (u > -db && u < db)
      u = 0;
    return u;
  endfunction

  function automatic longint millimetre_step(input longint u);
    longint mm;
    mm = (2 * u + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    if (mm > rpvs_pkg::STEP_MAX)
      mm = rpvs_pkg::STEP_MAX;
    else if (mm < rpvs_pkg::STEP_MIN)
      mm = rpvs_pkg::STEP_MIN;
    return mm;
  endfunction

  function automatic servo_result_t compute_servo_step(input logic [7:0] cls, input longint ox,
                                                       input longint oy, input longint hdg,
                                                       input longint px, input longint py);
    servo_result_t res;
    longint rx, ry, ux, uy, sx, sy;
    res.matched = 1'b0;
    res.reached = 1'b0;
    if (goal_idx < GOAL_COUNT && goal_idx < rpvs_pkg::LABEL_REGS &&
        cls == goal_label[goal_idx]) begin
      res.matched = 1'b1;
      rotate_by_heading(ox * (longint'(1) << FRACTION_BITS),
                        oy * (longint'(1) << FRACTION_BITS), hdg, rx, ry);
      ux = axis_effort(0, rx);
      uy = axis_effort(1, ry);
      if (ux == 0 && uy == 0) begin
        res.reached = 1'b1;
        goal_idx++;
      end
      sx = millimetre_step(ux);
      sy = millimetre_step(uy);
      // keep the previous increment when the move leaves the arena
      if (px + sx > rpvs_pkg::ARENA_X_LO && px + sx < rpvs_pkg::ARENA_X_HI)
        held_step[0] = sx;
      if (py + sy > rpvs_pkg::ARENA_Y_LO && py + sy < rpvs_pkg::ARENA_Y_HI)
        held_step[1] = sy;
    end
    res.step_x = held_step[0][13:0];
    res.step_y = held_step[1][13:0];
    res.goal   = goal_idx[GW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < rpvs_pkg::LABEL_REGS; k++)
        goal_label[k] = k[rpvs_pkg::LABEL_W-1:0];
      limit_px         = rpvs_pkg::LIMIT_RST;
      deadband_px      = rpvs_pkg::DEADBAND_RST;
      axis_integral[0] = 0;
      axis_integral[1] = 0;
      held_step[0]     = 0;
      held_step[1]     = 0;
      goal_idx         = 0;
      steps_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rpvs_pkg::REG_LABEL0:   goal_label[0] = cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LABEL1:   goal_label[1] = cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LABEL2:   goal_label[2] = cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LABEL3:   goal_label[3] = cfg_data[rpvs_pkg::LABEL_W-1:0];
          rpvs_pkg::REG_LIMIT:    limit_px = cfg_data[rpvs_pkg::LIMIT_W-1:0];
          rpvs_pkg::REG_DEADBAND: deadband_px = cfg_data[rpvs_pkg::DEADBAND_W-1:0];
          default: ;
        endcase
      end
      // retire the oldest request before taking a new one
      if (out_valid && !out_stall) begin
        if (steps_due.size() == 0) begin
          $display("%0t: servo step result with no request pending", $realtime);
          fail_count++;
        end else begin
          want = steps_due.pop_front();
          if (out_matched !== want.matched)
            flag_step_mismatch("matched", out_matched, want.matched);
          if (out_step_x_mm !== want.step_x)
            flag_step_mismatch("step_x_mm", out_step_x_mm, want.step_x);
          if (out_step_y_mm !== want.step_y)
            flag_step_mismatch("step_y_mm", out_step_y_mm, want.step_y);
          if (out_goal_reached !== want.reached)
            flag_step_mismatch("goal_reached", out_goal_reached, want.reached);
          if (out_goal_number !== want.goal)
            flag_step_mismatch("goal_number", out_goal_number, want.goal);
        end
      end
      if (in_valid && !in_stall)
        steps_due.push_back(compute_servo_step(in_object_class, in_offset_x, in_offset_y,
                                               in_heading, in_position_x_mm,
                                               in_position_y_mm));
    end
    pending <= steps_due.size();
  end

endmodule

@@ tb/rotated_pi_visual_servo_step_unit_test.sv @@
module rotated_pi_visual_servo_step_unit_test;

  localparam int GOAL_BITS = $clog2(rpvs_pkg::DEF_GOAL_COUNT + 1);
  localparam int CIW       = rpvs_pkg::CFG_IDX_W;
  localparam int CDW       = rpvs_pkg::CFG_DATA_W;
  // indexes past the last register; writes there must be ignored
  localparam logic [CIW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CIW-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_object_class = '0;
  logic signed [11:0]    in_offset_x = '0;
  logic signed [11:0]    in_offset_y = '0;
  logic signed [15:0]    in_heading = '0;
  logic signed [15:0]    in_position_x_mm = '0;
  logic signed [15:0]    in_position_y_mm = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic                  out_matched;
  logic signed [13:0]    out_step_x_mm;
  logic signed [13:0]    out_step_y_mm;
  logic                  out_goal_reached;
  logic [GOAL_BITS-1:0]  out_goal_number;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CIW-1:0]        cfg_index = '0;
  logic [CDW-1:0]        cfg_data = '0;
  int                    fail_count;
  int                    pending;

  logic [7:0]            label_shadow [rpvs_pkg::LABEL_REGS] = '{8'd0, 8'd1, 8'd2, 8'd3};
  bit                    no_idle = 1'b0;
  bit                    hold_stall = 1'b1;
  int                    hold_left = 0;
  int                    pick;

  always #2 clk = ~clk;

  rotated_pi_visual_servo_step_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_object_class  (in_object_class),
    .in_offset_x      (in_offset_x),
    .in_offset_y      (in_offset_y),
    .in_heading       (in_heading),
    .in_position_x_mm (in_position_x_mm),
    .in_position_y_mm (in_position_y_mm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_matched      (out_matched),
    .out_step_x_mm    (out_step_x_mm),
    .out_step_y_mm    (out_step_y_mm),
    .out_goal_reached (out_goal_reached),
    .out_goal_number  (out_goal_number),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  servo_step_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_object_class  (in_object_class),
    .in_offset_x      (in_offset_x),
    .in_offset_y      (in_offset_y),
    .in_heading       (in_heading),
    .in_position_x_mm (in_position_x_mm),
    .in_position_y_mm (in_position_y_mm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_matched      (out_matched),
    .out_step_x_mm    (out_step_x_mm),
    .out_step_y_mm    (out_step_y_mm),
    .out_goal_reached (out_goal_reached),
    .out_goal_number  (out_goal_number),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // result-side backpressure: short bursts mostly, now and then a long hold or a free run
  always @(posedge clk) begin
    if (hold_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        hold_stall = 1'b0;
        hold_left  = $urandom_range(1, 6);
      end else if (pick < 85) begin
        hold_stall = 1'b1;
        hold_left  = $urandom_range(1, 4);
      end else if (pick < 93) begin
        hold_stall = 1'b0;
        hold_left  = $urandom_range(40, 120);
      end else begin
        hold_stall = 1'b1;
        hold_left  = $urandom_range(15, 60);
      end
    end
    hold_left--;
    out_stall <= hold_stall;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  task automatic send_detection(input logic [7:0] cls, input logic [11:0] ox,
                                input logic [11:0] oy, input logic [15:0] hdg,
                                input logic [15:0] px, input logic [15:0] py);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_object_class  <= cls;
    in_offset_x      <= ox;
    in_offset_y      <= oy;
    in_heading       <= hdg;
    in_position_x_mm <= px;
    in_position_y_mm <= py;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every request has its result
  task automatic wait_steps_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_servo_reg(input logic [CIW-1:0] idx,
                                 input logic [CDW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rpvs_pkg::REG_LABEL0: label_shadow[0] = value[7:0];
      rpvs_pkg::REG_LABEL1: label_shadow[1] = value[7:0];
      rpvs_pkg::REG_LABEL2: label_shadow[2] = value[7:0];
      rpvs_pkg::REG_LABEL3: label_shadow[3] = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_servo_regs(input logic [CDW-1:0] l0, input logic [CDW-1:0] l1,
                                 input logic [CDW-1:0] l2, input logic [CDW-1:0] l3,
                                 input logic [CDW-1:0] lim,
                                 input logic [CDW-1:0] db,
                                 input logic [CIW-1:0] spare);
    write_servo_reg(rpvs_pkg::REG_LABEL0, l0);
    write_servo_reg(rpvs_pkg::REG_LABEL1, l1);
    write_servo_reg(rpvs_pkg::REG_LABEL2, l2);
    write_servo_reg(rpvs_pkg::REG_LABEL3, l3);
    write_servo_reg(rpvs_pkg::REG_LIMIT, lim);
    write_servo_reg(rpvs_pkg::REG_DEADBAND, db);
    // spare write last so an aliased index would corrupt live settings
    write_servo_reg(spare, CDW'($urandom_range(0, 8191)));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_detections(input int count, input int small_pct);
    logic [7:0]  cls;
    logic [11:0] ox, oy;
    logic [15:0] hdg, px, py;
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 55)
        cls = label_shadow[2'($urandom_range(0, rpvs_pkg::LABEL_REGS - 1))];
      else
        cls = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < small_pct) begin
        ox = 12'($urandom_range(0, 80) - 40);
        oy = 12'($urandom_range(0, 80) - 40);
      end else begin
        ox = 12'($urandom_range(0, 4095));
        oy = 12'($urandom_range(0, 4095));
      end
      case ($urandom_range(0, 15))
        0:       hdg = 16'h8000;
        1:       hdg = 16'h7fff;
        2:       hdg = 16'h4000;
        3:       hdg = 16'hc000;
        4:       hdg = 16'h4001;
        5:       hdg = 16'hbfff;
        6:       hdg = 16'h0000;
        default: hdg = 16'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 99) < 65) begin
        px = 16'($urandom_range(0, 3200) - 1100);
        py = 16'($urandom_range(0, 3200) - 1700);
      end else begin
        px = 16'($urandom_range(0, 65535));
        py = 16'($urandom_range(0, 65535));
      end
      send_detection(cls, ox, oy, hdg, px, py);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [7:0] base;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: labels 0..3, limit 2000, deadband 20
    send_detection(8'hff, 12'sd2047, -12'sd2048, 16'h8000, 16'h7fff, 16'h8000);
    send_detection(8'd0, 12'sd0, 12'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_detection(8'd0, 12'sd50, 12'sd50, 16'sd0, 16'sd0, 16'sd0);
    send_detection(8'd1, 12'sd2047, 12'sd2047, 16'sd0, 16'sd0, 16'sd0);
    send_detection(8'd1, -12'sd2048, -12'sd2048, 16'h8000, 16'h7fff, 16'h8000);
    send_detection(8'd1, 12'sd100, -12'sd100, 16'h7fff, 16'sd0, 16'sd0);
    send_detection(8'd1, 12'sd300, 12'sd0, 16'h4000, 16'sd1900, 16'sd0);
    send_detection(8'd1, 12'sd300, 12'sd0, 16'h4001, 16'sd0, 16'sd0);
    send_detection(8'd1, 12'sd300, 12'sd0, 16'hc000, 16'sd0, 16'sd0);
    send_detection(8'd1, 12'sd300, 12'sd0, 16'hbfff, 16'sd0, 16'sd0);
    send_detection(8'd1, -12'sd2048, 12'sd2047, 16'sd8192, 16'h8000, 16'h7fff);
    send_detection(8'd1, 12'sd500, 12'sd500, 16'sd0, 16'sd1990, 16'sd1490);
    send_detection(8'd1, -12'sd500, -12'sd500, 16'sd0, -16'sd690, -16'sd1290);
    send_detection(8'd1, 12'sd10, -12'sd10, 16'sd0, 16'sd0, 16'sd0);
    send_detection(8'd2, 12'sd10, -12'sd10, 16'sd0, 16'sd0, 16'sd0);
    wait_steps_drained();

    // no clamp headroom and no deadband: a goal is reached only when both rotated offsets are zero
    load_servo_regs(13'h1fff, 13'h0000, 13'h0080, 13'h00ff, 13'd0, 13'd0, REG_SPARE_LO);
    send_random_detections(160, 10);
    wait_steps_drained();

    load_servo_regs(CDW'($urandom_range(0, 8191)), CDW'($urandom_range(0, 8191)),
                    CDW'($urandom_range(0, 8191)), CDW'($urandom_range(0, 8191)),
                    13'h1fff, 13'd8, REG_SPARE_HI);
    send_random_detections(160, 5);
    wait_steps_drained();

    load_servo_regs(CDW'($urandom_range(0, 255)), CDW'($urandom_range(0, 255)),
                    CDW'($urandom_range(0, 255)), CDW'($urandom_range(0, 255)),
                    CDW'($urandom_range(1, 8190)), CDW'($urandom_range(1, 254)),
                    REG_SPARE_LO);
    send_random_detections(120, 15);
    wait_steps_drained();

    // widest deadband: walk through the remaining goals, then nothing matches
    base = 8'($urandom_range(0, 200));
    load_servo_regs(CDW'(base), CDW'(base) + 13'd1, CDW'(base) + 13'd2, 13'd255, 13'd2000,
                    13'd255, REG_SPARE_HI);
    for (int k = 0; k < rpvs_pkg::LABEL_REGS; k++)
      repeat (6)
        send_detection(label_shadow[k], 12'($urandom_range(0, 80) - 40),
                       12'($urandom_range(0, 80) - 40), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)));
    send_random_detections(20, 50);
    wait_steps_drained();

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rpvs_pkg.sv
rtl/core/rpvs_mul.sv
rtl/core/rpvs_cordic.sv
rtl/core/rotated_pi_visual_servo_step_unit.sv
tb/servo_step_checker.sv
tb/rotated_pi_visual_servo_step_unit_test.sv
